>>> rtl/csvcmd_pkg.sv
// ----------------------------------------------------------------------------
// CSV command parser package
// Shared types, byte classes, register indexes and parser phase codes.
// ----------------------------------------------------------------------------
package csvcmd_pkg;

   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_INDEX_BITS     = 8;
   localparam int CSR_DATA_BITS      = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MOVE_CODE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIRE_CODE = 8'd1;

   localparam logic [7:0] MOVE_CODE_RESET = 8'd0;
   localparam logic [7:0] FIRE_CODE_RESET = 8'd1;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FFEED   = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [2:0] CLS_NONE    = 3'd0;
   localparam logic [2:0] CLS_COMMA   = 3'd1;
   localparam logic [2:0] CLS_NEWLINE = 3'd2;
   localparam logic [2:0] CLS_DIGIT   = 3'd3;
   localparam logic [2:0] CLS_SPACE   = 3'd4;
   localparam logic [2:0] CLS_PLUS    = 3'd5;
   localparam logic [2:0] CLS_MINUS   = 3'd6;
   localparam logic [2:0] CLS_OTHER   = 3'd7;

   localparam logic [1:0] PHASE_SKIP   = 2'd0;
   localparam logic [1:0] PHASE_NUMBER = 2'd1;
   localparam logic [1:0] PHASE_ENDED  = 2'd2;

   localparam logic [1:0] FIELD_LAST = 2'd3;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] rx_byte;
      logic       clear_move;
      logic       clear_fire;
   } req_type;

   typedef struct packed {
      logic               move_pending;
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic               fire_pending;
   } rsp_type;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] digit;
      logic       clear_move;
      logic       clear_fire;
   } op_type;

   typedef struct packed {
      logic                      valid;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  wdata;
   } csr_write_type;

endpackage

>>> rtl/ascii_csv_command_parser_top.sv
// ----------------------------------------------------------------------------
// ASCII CSV command parser
// Parses lines of comma separated integers into move and fire commands.
//
// Channel   Direction  Ports
// request   in         req_valid, req_ready, req_data
// response  out        rsp_valid, rsp_ready, rsp_data
// csr       in         csr_valid, csr_ready, csr_index, csr_wdata
//
// One request per cycle is sustained while responses are taken; each request
// gives one response, held in the queue and then in the response register
// (classify on entry, queue, parse). The parser state update, including the
// multiply by ten, is combinational. Reset is synchronous; no clearing pass follows.
// A stalled response fills the two-entry queue, after which req_ready drops.
// ----------------------------------------------------------------------------
module ascii_csv_command_parser_top #(
   parameter int VALUE_BITS = csvcmd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  csvcmd_pkg::req_type                      req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output csvcmd_pkg::rsp_type                      rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [csvcmd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [csvcmd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic                      push;
   logic                      queue_full;
   logic                      queue_not_empty;
   logic                      pop;
   csvcmd_pkg::op_type        push_data;
   csvcmd_pkg::op_type        queue_data;
   csvcmd_pkg::csr_write_type csr;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   csvcmd_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   csvcmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_data)
   );

   csvcmd_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .queue_not_empty (queue_not_empty),
      .queue_data      (queue_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

>>> rtl/csvcmd_front.sv
// ----------------------------------------------------------------------------
// CSV command parser front end
// Accepts requests and classifies each received byte for the back end.
// ----------------------------------------------------------------------------
module csvcmd_front (
   input  csvcmd_pkg::req_type req_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                queue_full,
   output logic                push,
   output csvcmd_pkg::op_type  push_data
);

   logic [2:0] cls;
   logic [7:0] ch;

   assign ch = req_data.rx_byte;

   always_comb begin
      if (!req_data.has_byte) begin
         cls = csvcmd_pkg::CLS_NONE;
      end else begin
         unique case (ch) inside
            csvcmd_pkg::CHAR_COMMA:   cls = csvcmd_pkg::CLS_COMMA;
            csvcmd_pkg::CHAR_NEWLINE: cls = csvcmd_pkg::CLS_NEWLINE;
            csvcmd_pkg::CHAR_PLUS:    cls = csvcmd_pkg::CLS_PLUS;
            csvcmd_pkg::CHAR_MINUS:   cls = csvcmd_pkg::CLS_MINUS;
            csvcmd_pkg::CHAR_SPACE, csvcmd_pkg::CHAR_TAB, csvcmd_pkg::CHAR_VTAB,
            csvcmd_pkg::CHAR_FFEED, csvcmd_pkg::CHAR_CR:
               cls = csvcmd_pkg::CLS_SPACE;
            [csvcmd_pkg::CHAR_ZERO:csvcmd_pkg::CHAR_NINE]:
               cls = csvcmd_pkg::CLS_DIGIT;
            default:                  cls = csvcmd_pkg::CLS_OTHER;
         endcase
      end
   end

   // The low nibble of an ASCII digit is its value.
   assign req_ready            = !queue_full;
   assign push                 = req_valid && !queue_full;
   assign push_data.cls        = cls;
   assign push_data.digit      = ch[3:0];
   assign push_data.clear_move = req_data.clear_move;
   assign push_data.clear_fire = req_data.clear_fire;

endmodule

>>> rtl/csvcmd_queue.sv
// ----------------------------------------------------------------------------
// CSV command parser queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module csvcmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csvcmd_pkg::op_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output csvcmd_pkg::op_type pop_data
);

   localparam int PTR_BITS   = (csvcmd_pkg::QUEUE_DEPTH > 1) ?
                               $clog2(csvcmd_pkg::QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(csvcmd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(csvcmd_pkg::QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(csvcmd_pkg::QUEUE_DEPTH);

   csvcmd_pkg::op_type entry_ff [csvcmd_pkg::QUEUE_DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_MAX);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/csvcmd_back.sv
// ----------------------------------------------------------------------------
// CSV command parser back end
// Runs the field parser and command decode, one queued byte per cycle while the response is not stalled.
// ----------------------------------------------------------------------------
module csvcmd_back #(
   parameter int VALUE_BITS = csvcmd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  csvcmd_pkg::csr_write_type csr,
   input  logic                      queue_not_empty,
   input  csvcmd_pkg::op_type        queue_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csvcmd_pkg::rsp_type       rsp_data
);

   localparam int MB = VALUE_BITS - 1;
   localparam logic [MB-1:0] MAG_MAX = '1;

   logic [7:0]            move_code_ff, fire_code_ff;
   logic [1:0]            fi_ff, fi_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [MB-1:0]         mag_ff, mag_in;
   logic [VALUE_BITS-1:0] cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] xf_ff, xf_in;
   logic [VALUE_BITS-1:0] yf_ff, yf_in;
   logic [VALUE_BITS-1:0] xv_ff, xv_in;
   logic [VALUE_BITS-1:0] yv_ff, yv_in;
   logic                  move_flag_ff, move_flag_in;
   logic                  fire_flag_ff, fire_flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   csvcmd_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [MB+3:0]         mag_next;
   logic [VALUE_BITS-1:0] mag_ext;
   logic [VALUE_BITS-1:0] field_value;
   logic                  cmd_nonneg;
   logic [31:0]           xv_wide, yv_wide;

   assign pop       = queue_not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mag_next    = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0}
                        + (MB+4)'(queue_data.digit);
   assign mag_ext     = {1'b0, mag_ff};
   assign field_value = neg_ff ? (~mag_ext + VALUE_BITS'(1)) : mag_ext;

   always_comb begin
      fi_in        = fi_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cmd_in       = cmd_ff;
      xf_in        = xf_ff;
      yf_in        = yf_ff;
      xv_in        = xv_ff;
      yv_in        = yv_ff;
      move_flag_in = move_flag_ff;
      fire_flag_in = fire_flag_ff;
      cmd_nonneg   = 1'b0;
      if (pop) begin
         if (queue_data.clear_move) begin
            move_flag_in = 1'b0;
            xv_in        = '0;
            yv_in        = '0;
         end
         if (queue_data.clear_fire) begin
            fire_flag_in = 1'b0;
         end
         case (queue_data.cls)
            csvcmd_pkg::CLS_COMMA, csvcmd_pkg::CLS_NEWLINE: begin
               case (fi_ff)
                  2'd0:    cmd_in = field_value;
                  2'd1:    xf_in  = field_value;
                  2'd2:    yf_in  = field_value;
                  default: cmd_in = cmd_ff;
               endcase
               fi_in    = (fi_ff == csvcmd_pkg::FIELD_LAST) ? fi_ff : fi_ff + 1'b1;
               phase_in = csvcmd_pkg::PHASE_SKIP;
               neg_in   = 1'b0;
               mag_in   = '0;
               if (queue_data.cls == csvcmd_pkg::CLS_NEWLINE) begin
                  cmd_nonneg = !cmd_in[VALUE_BITS-1];
                  if (cmd_nonneg && cmd_in == VALUE_BITS'(move_code_ff)) begin
                     xv_in = xf_in;
                     yv_in = yf_in;
                     if (xf_in != '0 || yf_in != '0) begin
                        move_flag_in = 1'b1;
                     end
                  end else if (cmd_nonneg && cmd_in == VALUE_BITS'(fire_code_ff)) begin
                     fire_flag_in = 1'b1;
                  end
                  fi_in  = '0;
                  cmd_in = '0;
                  xf_in  = '0;
                  yf_in  = '0;
               end
            end
            csvcmd_pkg::CLS_NONE: begin
               phase_in = phase_ff;
            end
            default: begin
               if (!phase_ff[1]) begin
                  if (queue_data.cls == csvcmd_pkg::CLS_DIGIT) begin
                     mag_in   = (mag_next[MB+3:MB] != '0) ? MAG_MAX : mag_next[MB-1:0];
                     phase_in = csvcmd_pkg::PHASE_NUMBER;
                  end else if (phase_ff == csvcmd_pkg::PHASE_SKIP &&
                               queue_data.cls == csvcmd_pkg::CLS_SPACE) begin
                     phase_in = csvcmd_pkg::PHASE_SKIP;
                  end else if (phase_ff == csvcmd_pkg::PHASE_SKIP &&
                               queue_data.cls == csvcmd_pkg::CLS_PLUS) begin
                     phase_in = csvcmd_pkg::PHASE_NUMBER;
                  end else if (phase_ff == csvcmd_pkg::PHASE_SKIP &&
                               queue_data.cls == csvcmd_pkg::CLS_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = csvcmd_pkg::PHASE_NUMBER;
                  end else begin
                     phase_in = csvcmd_pkg::PHASE_ENDED;
                  end
               end
            end
         endcase
      end
   end

   assign xv_wide = 32'(xv_in);
   assign yv_wide = 32'(yv_in);

   always_comb begin
      rsp_data_in.move_pending = move_flag_in;
      rsp_data_in.x_offset     = xv_wide[15:0];
      rsp_data_in.y_offset     = yv_wide[15:0];
      rsp_data_in.fire_pending = fire_flag_in;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_code_ff <= csvcmd_pkg::MOVE_CODE_RESET;
         fire_code_ff <= csvcmd_pkg::FIRE_CODE_RESET;
         fi_ff        <= '0;
         phase_ff     <= csvcmd_pkg::PHASE_SKIP;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         cmd_ff       <= '0;
         xf_ff        <= '0;
         yf_ff        <= '0;
         xv_ff        <= '0;
         yv_ff        <= '0;
         move_flag_ff <= 1'b0;
         fire_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.index == csvcmd_pkg::REG_MOVE_CODE) begin
            move_code_ff <= csr.wdata;
         end
         if (csr.valid && csr.index == csvcmd_pkg::REG_FIRE_CODE) begin
            fire_code_ff <= csr.wdata;
         end
         fi_ff        <= fi_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         cmd_ff       <= cmd_in;
         xf_ff        <= xf_in;
         yf_ff        <= yf_in;
         xv_ff        <= xv_in;
         yv_ff        <= yv_in;
         move_flag_ff <= move_flag_in;
         fire_flag_ff <= fire_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A newline always closes the line and restarts field counting.
   a_newline_resets_fields: assert property (@(posedge clock) disable iff (reset)
      pop && queue_data.cls == csvcmd_pkg::CLS_NEWLINE |=> fi_ff == '0 && cmd_ff == '0)
      else $error("field state not cleared after newline");

   // Move pending can only be raised by a newline.
   a_move_from_newline: assert property (@(posedge clock) disable iff (reset)
      $rose(move_flag_ff) |-> $past(pop && queue_data.cls == csvcmd_pkg::CLS_NEWLINE))
      else $error("move pending raised without a newline");

   // Fire pending can only be raised by a newline.
   a_fire_from_newline: assert property (@(posedge clock) disable iff (reset)
      $rose(fire_flag_ff) |-> $past(pop && queue_data.cls == csvcmd_pkg::CLS_NEWLINE))
      else $error("fire pending raised without a newline");

   // A clear without a newline leaves the offsets at zero.
   a_clear_move: assert property (@(posedge clock) disable iff (reset)
      pop && queue_data.clear_move && queue_data.cls != csvcmd_pkg::CLS_NEWLINE
      |=> !move_flag_ff && xv_ff == '0 && yv_ff == '0)
      else $error("move clear not applied");

endmodule

>>> tb/sv/ascii_csv_command_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII CSV command parser testbench
// Sends lines of comma separated numbers, noise bytes and acknowledge pulses
// through the request channel. A behavioral parser computes the status after
// every request, and each response is compared with it. The command codes
// are reprogrammed between phases. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module ascii_csv_command_parser_top_tb;

   localparam int ITEMS_PER_PHASE = 100;
   localparam int PHASES          = 5;
   localparam int DIR_ROWS        = 27;

   typedef struct {
      bit         has_byte;
      logic [7:0] rx_byte;
      bit         clear_move;
      bit         clear_fire;
      bit         check;
      bit         move_pending;
      int         x_offset;
      int         y_offset;
      bit         fire_pending;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   csvcmd_pkg::req_type                   req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   csvcmd_pkg::rsp_type                   rsp_data;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [csvcmd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [csvcmd_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Parser state and command codes as the block should hold them.
   logic [7:0]  move_code_reg;
   logic [7:0]  fire_code_reg;
   logic [1:0]  field_idx;
   logic [1:0]  phase;
   logic        neg;
   logic [14:0] mag;
   logic [15:0] cmd_field;
   logic [15:0] x_field;
   logic [15:0] y_field;
   logic [15:0] x_val;
   logic [15:0] y_val;
   logic        move_flag;
   logic        fire_flag;

   csvcmd_pkg::rsp_type predicted_status_q[$];
   int      error_count = 0;
   int      sent_count  = 0;
   bit      gaps_on     = 1'b1;
   bit      stall_on    = 1'b1;
   int      stall_left  = 0;

   logic [7:0] blanks [5] = '{csvcmd_pkg::CHAR_SPACE, csvcmd_pkg::CHAR_TAB,
                              csvcmd_pkg::CHAR_VTAB, csvcmd_pkg::CHAR_FFEED,
                              csvcmd_pkg::CHAR_CR};

   dir_row_type dir_table [DIR_ROWS] = '{
      '{0, 8'h00,                    0, 0, 1, 0, 0,     0,  0},
      '{1, "0",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_COMMA,   0, 0, 0, 0, 0,     0,  0},
      '{1, "9",                      0, 0, 0, 0, 0,     0,  0},
      '{1, "9",                      0, 0, 0, 0, 0,     0,  0},
      '{1, "9",                      0, 0, 0, 0, 0,     0,  0},
      '{1, "9",                      0, 0, 0, 0, 0,     0,  0},
      '{1, "9",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_COMMA,   0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_MINUS,   0, 0, 0, 0, 0,     0,  0},
      '{1, "7",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_NEWLINE, 0, 0, 1, 1, 32767, -7, 0},
      '{1, csvcmd_pkg::CHAR_TAB,     0, 0, 0, 0, 0,     0,  0},
      '{1, "0",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_NEWLINE, 0, 0, 1, 1, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_MINUS,   1, 1, 1, 0, 0,     0,  0},
      '{1, "1",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_NEWLINE, 0, 0, 1, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_PLUS,    0, 0, 0, 0, 0,     0,  0},
      '{1, "1",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_COMMA,   0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_COMMA,   0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_COMMA,   0, 0, 0, 0, 0,     0,  0},
      '{1, "4",                      0, 0, 0, 0, 0,     0,  0},
      '{1, csvcmd_pkg::CHAR_NEWLINE, 0, 0, 1, 0, 0,     0,  1},
      '{0, 8'hFF,                    0, 1, 1, 0, 0,     0,  0},
      '{1, 8'hFF,                    0, 0, 0, 0, 0,     0,  0}
   };

   ascii_csv_command_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void reset_parser();
      move_code_reg = csvcmd_pkg::MOVE_CODE_RESET;
      fire_code_reg = csvcmd_pkg::FIRE_CODE_RESET;
      field_idx     = '0;
      phase         = csvcmd_pkg::PHASE_SKIP;
      neg           = 1'b0;
      mag           = '0;
      cmd_field     = '0;
      x_field       = '0;
      y_field       = '0;
      x_val         = '0;
      y_val         = '0;
      move_flag     = 1'b0;
      fire_flag     = 1'b0;
   endfunction

   function automatic csvcmd_pkg::rsp_type parse_request(input csvcmd_pkg::req_type r);
      csvcmd_pkg::rsp_type s;
      logic [7:0]  c;
      logic [15:0] v;
      int unsigned m;
      c = r.rx_byte;
      if (r.clear_move) begin
         move_flag = 1'b0;
         x_val     = '0;
         y_val     = '0;
      end
      if (r.clear_fire) fire_flag = 1'b0;
      if (r.has_byte) begin
         if (c == csvcmd_pkg::CHAR_COMMA || c == csvcmd_pkg::CHAR_NEWLINE) begin
            v = {1'b0, mag};
            if (neg) v = -v;
            case (field_idx)
               2'd0: cmd_field = v;
               2'd1: x_field = v;
               2'd2: y_field = v;
               default: ;
            endcase
            if (field_idx != csvcmd_pkg::FIELD_LAST) field_idx = field_idx + 2'd1;
            phase = csvcmd_pkg::PHASE_SKIP;
            neg   = 1'b0;
            mag   = '0;
            if (c == csvcmd_pkg::CHAR_NEWLINE) begin
               if (!cmd_field[15] && cmd_field == {8'd0, move_code_reg}) begin
                  x_val = x_field;
                  y_val = y_field;
                  if (x_field != '0 || y_field != '0) move_flag = 1'b1;
               end else if (!cmd_field[15] && cmd_field == {8'd0, fire_code_reg}) begin
                  fire_flag = 1'b1;
               end
               field_idx = '0;
               cmd_field = '0;
               x_field   = '0;
               y_field   = '0;
            end
         end else if (phase == csvcmd_pkg::PHASE_SKIP ||
                      phase == csvcmd_pkg::PHASE_NUMBER) begin
            if (c >= csvcmd_pkg::CHAR_ZERO && c <= csvcmd_pkg::CHAR_NINE) begin
               m     = 32'(mag) * 10 + 32'(c - csvcmd_pkg::CHAR_ZERO);
               mag   = (m > 32767) ? 15'h7FFF : m[14:0];
               phase = csvcmd_pkg::PHASE_NUMBER;
            end else if (phase == csvcmd_pkg::PHASE_SKIP &&
                         (c == csvcmd_pkg::CHAR_SPACE ||
                          (c >= csvcmd_pkg::CHAR_TAB && c <= csvcmd_pkg::CHAR_CR))) begin
               phase = csvcmd_pkg::PHASE_SKIP;
            end else if (phase == csvcmd_pkg::PHASE_SKIP && c == csvcmd_pkg::CHAR_PLUS) begin
               phase = csvcmd_pkg::PHASE_NUMBER;
            end else if (phase == csvcmd_pkg::PHASE_SKIP && c == csvcmd_pkg::CHAR_MINUS) begin
               neg   = 1'b1;
               phase = csvcmd_pkg::PHASE_NUMBER;
            end else begin
               phase = csvcmd_pkg::PHASE_ENDED;
            end
         end
      end
      s.move_pending = move_flag;
      s.x_offset     = x_val;
      s.y_offset     = y_val;
      s.fire_pending = fire_flag;
      return s;
   endfunction

   task automatic send_req(input csvcmd_pkg::req_type r);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_status_q.push_back(parse_request(r));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [csvcmd_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [csvcmd_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == csvcmd_pkg::REG_MOVE_CODE) move_code_reg = data;
      else if (index == csvcmd_pkg::REG_FIRE_CODE) fire_code_reg = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_line();
      logic [7:0] q[$];
      csvcmd_pkg::req_type r;
      string      text;
      int         val;
      int         sel;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) q.push_back(csvcmd_pkg::CHAR_NEWLINE);
      end else begin
         for (int f = 0; f < int'($urandom_range(0, 5)); f++) begin
            if (f > 0) q.push_back(csvcmd_pkg::CHAR_COMMA);
            if ($urandom_range(0, 3) == 0) q.push_back(blanks[$urandom_range(0, 4)]);
            sel = $urandom_range(0, 9);
            if (f == 0 && sel < 4) val = move_code_reg;
            else if (f == 0 && sel < 7) val = fire_code_reg;
            else if (sel == 9) val = $urandom_range(30000, 2000000);
            else val = $urandom_range(0, 300);
            if ($urandom_range(0, 3) == 0) val = -val;
            if (val >= 0 && $urandom_range(0, 7) == 0) q.push_back(csvcmd_pkg::CHAR_PLUS);
            text = $sformatf("%0d", val);
            if ($urandom_range(0, 15) != 0) begin
               for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
            end
            if ($urandom_range(0, 7) == 0) q.push_back(8'($urandom_range(0, 255)));
         end
         q.push_back(csvcmd_pkg::CHAR_NEWLINE);
      end
      foreach (q[i]) begin
         if ($urandom_range(0, 9) == 0) begin
            r.has_byte   = 1'b0;
            r.rx_byte    = 8'($urandom_range(0, 255));
            r.clear_move = 1'($urandom_range(0, 1));
            r.clear_fire = 1'($urandom_range(0, 1));
            send_req(r);
         end
         r.has_byte   = 1'b1;
         r.rx_byte    = q[i];
         r.clear_move = ($urandom_range(0, 19) == 0);
         r.clear_fire = ($urandom_range(0, 19) == 0);
         send_req(r);
      end
   endtask

   always @(posedge clock) begin
      csvcmd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_status_q.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = predicted_status_q.pop_front();
               if (rsp_data.move_pending !== want.move_pending) begin
                  $error("move_pending: expected %0d, actual %0d",
                         want.move_pending, rsp_data.move_pending);
                  error_count++;
               end
               if (rsp_data.x_offset !== want.x_offset) begin
                  $error("x_offset: expected %0d, actual %0d",
                         want.x_offset, rsp_data.x_offset);
                  error_count++;
               end
               if (rsp_data.y_offset !== want.y_offset) begin
                  $error("y_offset: expected %0d, actual %0d",
                         want.y_offset, rsp_data.y_offset);
                  error_count++;
               end
               if (rsp_data.fire_pending !== want.fire_pending) begin
                  $error("fire_pending: expected %0d, actual %0d",
                         want.fire_pending, rsp_data.fire_pending);
                  error_count++;
               end
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      csvcmd_pkg::req_type r;
      csvcmd_pkg::rsp_type typed;
      logic [7:0] code;
      reset_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         r.has_byte   = dir_table[i].has_byte;
         r.rx_byte    = dir_table[i].rx_byte;
         r.clear_move = dir_table[i].clear_move;
         r.clear_fire = dir_table[i].clear_fire;
         send_req(r);
         if (dir_table[i].check) begin
            typed.move_pending = dir_table[i].move_pending;
            typed.x_offset     = 16'(dir_table[i].x_offset);
            typed.y_offset     = 16'(dir_table[i].y_offset);
            typed.fire_pending = dir_table[i].fire_pending;
            predicted_status_q[predicted_status_q.size() - 1] = typed;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            case (p)
               1: begin
                  write_reg(csvcmd_pkg::REG_MOVE_CODE, 8'd255);
                  write_reg(csvcmd_pkg::REG_FIRE_CODE, 8'd0);
                  write_reg(csvcmd_pkg::CSR_INDEX_BITS'($urandom_range(2, 255)),
                            csvcmd_pkg::CSR_DATA_BITS'($urandom_range(0, 255)));
               end
               2: begin
                  code = 8'($urandom_range(0, 20));
                  write_reg(csvcmd_pkg::REG_MOVE_CODE, code);
                  write_reg(csvcmd_pkg::REG_FIRE_CODE, code);
               end
               3: begin
                  write_reg(csvcmd_pkg::REG_MOVE_CODE, 8'($urandom_range(0, 30)));
                  write_reg(csvcmd_pkg::REG_FIRE_CODE, 8'($urandom_range(0, 30)));
               end
               default: begin
                  write_reg(csvcmd_pkg::REG_MOVE_CODE, 8'd0);
                  write_reg(csvcmd_pkg::REG_FIRE_CODE, 8'd255);
               end
            endcase
         end
         sent_count = 0;
         while (sent_count < ITEMS_PER_PHASE) begin
            if (p == PHASES - 1) begin
               gaps_on  = 1'b0;
               stall_on = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               gaps_on  = ~gaps_on;
               stall_on = ~stall_on;
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
            send_line();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> ascii_csv_command_parser_top.f
rtl/csvcmd_pkg.sv
rtl/csvcmd_front.sv
rtl/csvcmd_queue.sv
rtl/csvcmd_back.sv
rtl/ascii_csv_command_parser_top.sv
tb/sv/ascii_csv_command_parser_top_tb.sv
